### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, quiet while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hw/rtl/elt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package elt_pkg;

	localparam int unsigned VAL_W      = 32;
	localparam int unsigned CMP_W      = 33;
	localparam int unsigned SUM_W      = 57;
	localparam int unsigned CNT_W      = 25;
	localparam int unsigned DIV_W      = 58;
	localparam int unsigned REM_W      = 26;
	localparam int unsigned SQ_W       = 64;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned RAD2_W     = 63;
	localparam int unsigned CTR_W      = 6;

	localparam longint unsigned ELT_MAX_POINTS = 64'd16777216;

	// Opcodes
	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_BEGIN  = 2'd0;
	localparam opcode_t OP_SAMPLE = 2'd1;
	localparam opcode_t OP_FINISH = 2'd2;

	// Register indexes
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_COMPARE_MODE = 3'd0;
	localparam reg_idx_t REG_REGION_MODE  = 3'd1;
	localparam reg_idx_t REG_HALF_SPACE   = 3'd2;
	localparam reg_idx_t REG_CENTER_X     = 3'd3;
	localparam reg_idx_t REG_CENTER_Y     = 3'd4;
	localparam reg_idx_t REG_CENTER_Z     = 3'd5;
	localparam reg_idx_t REG_RADIUS_SQ    = 3'd6;

	// Region and half-space codes
	localparam logic [1:0] REGION_FIXED  = 2'd1;
	localparam logic [1:0] REGION_FOLLOW = 2'd2;
	localparam logic [1:0] HALF_SKIP_NEG = 2'd1;
	localparam logic [1:0] HALF_SKIP_POS = 2'd2;

	// Sum selection for the divider
	typedef logic [2:0] sel_t;
	localparam sel_t SEL_VALUE   = 3'd0;
	localparam sel_t SEL_COMPARE = 3'd1;
	localparam sel_t SEL_X       = 3'd2;
	localparam sel_t SEL_Y       = 3'd3;
	localparam sel_t SEL_Z       = 3'd4;
	localparam sel_t SEL_LAST    = SEL_Z;

	// Axis codes for the shared squarer
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;

	// Sequencer last-step indexes
	localparam logic [CTR_W-1:0] SQR_LAST = 6'd3;
	localparam logic [CTR_W-1:0] DIV_LAST = 6'd59;
	localparam logic [CTR_W-1:0] SQT_LAST = 6'd33;

	typedef struct packed {
		logic       latch;
		logic       clear;
		logic       mul_en;
		logic       mul_mean;
		logic [1:0] axis;
		logic       acc_clr;
		logic       acc_add;
		logic       update;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		sel_t       sel;
		logic       sq_load;
		logic       sq_step;
		logic       commit;
		logic       out_load;
	} elt_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/elt_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface elt_in_if import elt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	opcode_t                 opcode;
	logic signed [VAL_W-1:0] sample_value;
	logic signed [VAL_W-1:0] x_coord;
	logic signed [VAL_W-1:0] y_coord;
	logic signed [VAL_W-1:0] z_coord;
	logic                    skip_point;
	modport source (output valid, opcode, sample_value, x_coord, y_coord, z_coord, skip_point,
		input ready);
	modport sink (input valid, opcode, sample_value, x_coord, y_coord, z_coord, skip_point,
		output ready);
endinterface

interface elt_out_if import elt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] mean_value;
	logic signed [VAL_W-1:0] mean_compare;
	logic signed [VAL_W-1:0] mean_x;
	logic signed [VAL_W-1:0] mean_y;
	logic signed [VAL_W-1:0] mean_z;
	logic [VAL_W-1:0]        radius;
	logic [CNT_W-1:0]        tie_count;
	logic                    valid_res;
	modport source (output valid, mean_value, mean_compare, mean_x, mean_y, mean_z, radius,
		tie_count, valid_res, input ready);
	modport sink (input valid, mean_value, mean_compare, mean_x, mean_y, mean_z, radius,
		tie_count, valid_res, output ready);
endinterface

interface elt_cfg_if import elt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	reg_idx_t              index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/elt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module elt_datapath import elt_pkg::*; #(
	parameter longint unsigned MAX_POINTS = ELT_MAX_POINTS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire elt_cmd_t                cmd,
	input  wire logic signed [VAL_W-1:0] sample_value,
	input  wire logic signed [VAL_W-1:0] x_coord,
	input  wire logic signed [VAL_W-1:0] y_coord,
	input  wire logic signed [VAL_W-1:0] z_coord,
	input  wire logic                    skip_point,
	input  wire logic                    cfg_we,
	input  wire reg_idx_t                cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	output logic signed [VAL_W-1:0]      mean_value,
	output logic signed [VAL_W-1:0]      mean_compare,
	output logic signed [VAL_W-1:0]      mean_x,
	output logic signed [VAL_W-1:0]      mean_y,
	output logic signed [VAL_W-1:0]      mean_z,
	output logic [VAL_W-1:0]             radius,
	output logic [CNT_W-1:0]             tie_count,
	output logic                         valid_res
);

	localparam logic [CNT_W-1:0] CNT_CAP =
		(MAX_POINTS > 64'd33554431) ? {CNT_W{1'b1}} : MAX_POINTS[CNT_W-1:0];

	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
		input logic signed [CMP_W-1:0] b);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {{(SUM_W+1-CMP_W){b[CMP_W-1]}}, b};
		if (s[SUM_W] != s[SUM_W-1])
			return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return s[SUM_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] mag_diff(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W:0] d;
		d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		return d[VAL_W] ? VAL_W'(-d) : d[VAL_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] sext_val(input logic signed [CMP_W-1:0] v);
		return {{(SUM_W-CMP_W){v[CMP_W-1]}}, v};
	endfunction

	// Configuration registers
	logic [1:0]              compare_mode_q, region_mode_q, half_space_q;
	logic signed [VAL_W-1:0] center_x_q, center_y_q, center_z_q;
	logic [RAD2_W-1:0]       radius_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_mode_q <= '0;
			region_mode_q  <= '0;
			half_space_q   <= '0;
			center_x_q     <= '0;
			center_y_q     <= '0;
			center_z_q     <= '0;
			radius_sq_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COMPARE_MODE: compare_mode_q <= cfg_data[1:0];
				REG_REGION_MODE:  region_mode_q  <= cfg_data[1:0];
				REG_HALF_SPACE:   half_space_q   <= cfg_data[1:0];
				REG_CENTER_X:     center_x_q     <= cfg_data[VAL_W-1:0];
				REG_CENTER_Y:     center_y_q     <= cfg_data[VAL_W-1:0];
				REG_CENTER_Z:     center_z_q     <= cfg_data[VAL_W-1:0];
				REG_RADIUS_SQ:    radius_sq_q    <= cfg_data[RAD2_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold the sample under work
	logic signed [VAL_W-1:0] v_q, x_q, y_q, z_q;
	logic                    skip_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			v_q    <= sample_value;
			x_q    <= x_coord;
			y_q    <= y_coord;
			z_q    <= z_coord;
			skip_q <= skip_point;
		end
	end

	// Accumulator and follow state
	logic signed [CMP_W-1:0] best_q;
	logic signed [SUM_W-1:0] vsum_q, csum_q, xsum_q, ysum_q, zsum_q;
	logic [CNT_W-1:0]        count_q;
	logic                    have_follow_q;
	logic signed [VAL_W-1:0] follow_x_q, follow_y_q, follow_z_q;
	logic signed [VAL_W-1:0] mv_q, mc_q, mx_q, my_q, mz_q;

	// Pick the sphere centre
	logic                    use_follow;
	logic signed [VAL_W-1:0] cx, cy, cz;
	assign use_follow = (region_mode_q == REGION_FOLLOW) && have_follow_q;
	assign cx = use_follow ? follow_x_q : center_x_q;
	assign cy = use_follow ? follow_y_q : center_y_q;
	assign cz = use_follow ? follow_z_q : center_z_q;

	// Shared squarer and saturating sum of squares
	logic [VAL_W-1:0]  mul_a;
	logic [SQ_W-1:0]   prod_w, prod_q, acc2_q;
	logic [SQ_W:0]     acc_sum;
	logic signed [VAL_W-1:0] mean_sel;

	always_comb begin
		case (cmd.axis)
			AXIS_X:  mean_sel = mx_q;
			AXIS_Y:  mean_sel = my_q;
			default: mean_sel = mz_q;
		endcase
		if (cmd.mul_mean)
			mul_a = mag_diff(mean_sel, '0);
		else begin
			case (cmd.axis)
				AXIS_X:  mul_a = mag_diff(x_q, cx);
				AXIS_Y:  mul_a = mag_diff(y_q, cy);
				default: mul_a = mag_diff(z_q, cz);
			endcase
		end
	end

	assign prod_w  = {{(SQ_W-VAL_W){1'b0}}, mul_a} * {{(SQ_W-VAL_W){1'b0}}, mul_a};
	assign acc_sum = {1'b0, acc2_q} + {1'b0, prod_q};

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= prod_w;
		if (cmd.acc_clr)
			acc2_q <= '0;
		else if (cmd.acc_add)
			acc2_q <= acc_sum[SQ_W] ? {SQ_W{1'b1}} : acc_sum[SQ_W-1:0];
	end

	// Qualify the sample and compare against the extremum
	logic                    hs_fail, out_sphere, qualify, better, restart, tie;
	logic signed [CMP_W-1:0] cval, vext, xext, yext, zext;

	always_comb begin
		hs_fail = ((half_space_q == HALF_SKIP_NEG) && (x_q < 0)) ||
			((half_space_q == HALF_SKIP_POS) && (x_q > 0));
		out_sphere = ((region_mode_q == REGION_FIXED) || (region_mode_q == REGION_FOLLOW)) &&
			(acc2_q > {1'b0, radius_sq_q});
		qualify = !skip_q && !hs_fail && !out_sphere;
		vext = {v_q[VAL_W-1], v_q};
		xext = {x_q[VAL_W-1], x_q};
		yext = {y_q[VAL_W-1], y_q};
		zext = {z_q[VAL_W-1], z_q};
		cval = (compare_mode_q[1] && v_q[VAL_W-1]) ? -vext : vext;
		better = compare_mode_q[0] ? (cval < best_q) : (cval > best_q);
		restart = (count_q == '0) || better;
		tie = (cval == best_q) && (count_q < CNT_CAP);
	end

	// Divider: sum select, magnitude and rounding bias
	logic signed [SUM_W-1:0] div_sum;
	logic [DIV_W-1:0]        div_mag, dvd_q;
	logic [REM_W-1:0]        rem_q;
	logic                    neg_q;
	logic [REM_W:0]          trial;
	logic                    big;
	logic signed [VAL_W-1:0] div_res;

	always_comb begin
		case (cmd.sel)
			SEL_VALUE:   div_sum = vsum_q;
			SEL_COMPARE: div_sum = csum_q;
			SEL_X:       div_sum = xsum_q;
			SEL_Y:       div_sum = ysum_q;
			default:     div_sum = zsum_q;
		endcase
		div_mag = div_sum[SUM_W-1] ? -{div_sum[SUM_W-1], div_sum} : {1'b0, div_sum};
		trial = {rem_q, dvd_q[DIV_W-1]} - {{(REM_W+1-CNT_W){1'b0}}, count_q};
		big = |dvd_q[DIV_W-1:VAL_W-1];
		if (neg_q)
			div_res = big ? {1'b1, {(VAL_W-1){1'b0}}} : -dvd_q[VAL_W-1:0];
		else
			div_res = big ? {1'b0, {(VAL_W-1){1'b1}}} : dvd_q[VAL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q <= div_mag + {{(DIV_W-CNT_W+1){1'b0}}, count_q[CNT_W-1:1]};
			rem_q <= '0;
			neg_q <= div_sum[SUM_W-1];
		end else if (cmd.div_step) begin
			if (!trial[REM_W]) begin
				rem_q <= trial[REM_W-1:0];
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[REM_W-2:0], dvd_q[DIV_W-1]};
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			end
		end
		if (cmd.div_store) begin
			case (cmd.sel)
				SEL_VALUE:   mv_q <= div_res;
				SEL_COMPARE: mc_q <= div_res;
				SEL_X:       mx_q <= div_res;
				SEL_Y:       my_q <= div_res;
				default:     mz_q <= div_res;
			endcase
		end
	end

	// Square root, two bits per step
	logic [SQ_W-1:0] sq_v_q, sq_res_q, sq_bit_q, sq_t;
	assign sq_t = sq_res_q + sq_bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			sq_v_q   <= acc2_q;
			sq_res_q <= '0;
			sq_bit_q <= {2'b01, {(SQ_W-2){1'b0}}};
		end else if (cmd.sq_step) begin
			if (sq_v_q >= sq_t) begin
				sq_v_q   <= sq_v_q - sq_t;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// Update accumulators and follow centre
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q        <= '0;
			vsum_q        <= '0;
			csum_q        <= '0;
			xsum_q        <= '0;
			ysum_q        <= '0;
			zsum_q        <= '0;
			count_q       <= '0;
			have_follow_q <= 1'b0;
			follow_x_q    <= '0;
			follow_y_q    <= '0;
			follow_z_q    <= '0;
		end else begin
			if (cmd.clear) begin
				best_q  <= '0;
				vsum_q  <= '0;
				csum_q  <= '0;
				xsum_q  <= '0;
				ysum_q  <= '0;
				zsum_q  <= '0;
				count_q <= '0;
			end else if (cmd.update && qualify) begin
				if (restart) begin
					best_q  <= cval;
					vsum_q  <= sext_val(vext);
					csum_q  <= sext_val(cval);
					xsum_q  <= sext_val(xext);
					ysum_q  <= sext_val(yext);
					zsum_q  <= sext_val(zext);
					count_q <= {{(CNT_W-1){1'b0}}, 1'b1};
				end else if (tie) begin
					vsum_q  <= sat_add(vsum_q, vext);
					csum_q  <= sat_add(csum_q, cval);
					xsum_q  <= sat_add(xsum_q, xext);
					ysum_q  <= sat_add(ysum_q, yext);
					zsum_q  <= sat_add(zsum_q, zext);
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.commit && (region_mode_q == REGION_FOLLOW) && (count_q != '0)) begin
				have_follow_q <= 1'b1;
				follow_x_q    <= mx_q;
				follow_y_q    <= my_q;
				follow_z_q    <= mz_q;
			end
		end
	end

	// Result register
	logic has_pts;
	assign has_pts = (count_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_value   <= has_pts ? mv_q : '0;
			mean_compare <= has_pts ? mc_q : '0;
			mean_x       <= has_pts ? mx_q : '0;
			mean_y       <= has_pts ? my_q : '0;
			mean_z       <= has_pts ? mz_q : '0;
			radius       <= has_pts ? sq_res_q[VAL_W-1:0] : '0;
			tie_count    <= count_q;
			valid_res    <= has_pts;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/elt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module elt_ctrl import elt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire opcode_t opcode,
	output logic         in_ready,
	input  wire logic    out_ready,
	output logic         out_valid,
	output elt_cmd_t     cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIST = 7'b0000010,
		ST_UPD  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_RSQ  = 7'b0010000,
		ST_SQRT = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [CTR_W-1:0] cnt_q, cnt_d;
	sel_t             sel_q, sel_d;
	logic             out_valid_q, in_acc, out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Sequence the datapath
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + 1'b1;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.sel = sel_q;
		cmd.axis = cnt_q[1:0];
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				sel_d = SEL_VALUE;
				if (in_acc) begin
					case (opcode)
						OP_BEGIN:  cmd.clear = 1'b1;
						OP_SAMPLE: begin
							cmd.latch = 1'b1;
							state_d   = ST_DIST;
						end
						OP_FINISH: state_d = ST_DIV;
						default: ;
					endcase
				end
			end
			ST_DIST, ST_RSQ: begin
				cmd.mul_mean = (state_q == ST_RSQ);
				cmd.mul_en   = (cnt_q != SQR_LAST);
				cmd.acc_clr  = (cnt_q == '0);
				cmd.acc_add  = (cnt_q != '0);
				if (cnt_q == SQR_LAST) begin
					cnt_d   = '0;
					state_d = (state_q == ST_RSQ) ? ST_SQRT : ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_load  = (cnt_q == '0);
				cmd.div_step  = (cnt_q != '0) && (cnt_q != DIV_LAST);
				cmd.div_store = (cnt_q == DIV_LAST);
				if (cnt_q == DIV_LAST) begin
					cnt_d = '0;
					if (sel_q == SEL_LAST)
						state_d = ST_RSQ;
					else
						sel_d = sel_q + 1'b1;
				end
			end
			ST_SQRT: begin
				cmd.sq_load = (cnt_q == '0);
				cmd.sq_step = (cnt_q != '0) && (cnt_q != SQT_LAST);
				cmd.commit  = (cnt_q == SQT_LAST);
				if (cnt_q == SQT_LAST) begin
					cnt_d   = '0;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				cnt_d = '0;
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_q       <= SEL_VALUE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`ASSERT_CLK(a_sel_range, clk, arst_n, sel_q <= SEL_LAST)
	`ASSERT_CLK(a_cnt_range, clk, arst_n, cnt_q <= DIV_LAST)
	`ASSERT_CLK(a_load_sets_valid, clk, arst_n, cmd.out_load |=> out_valid_q)
	`ASSERT_CLK(a_div_to_rsq, clk, arst_n, (cmd.div_store && sel_q == SEL_LAST) |=> state_q == ST_RSQ)

endmodule
`default_nettype wire

### hw/rtl/extremum_location_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Extremum location tracker.
// smp carries items: begin (clear accumulators), sample (value and x,y,z, skip flag)
// and finish (emit averages). res carries one result per finish item. cfg writes
// the configuration registers by index and is always ready; write only while idle.
// Item steps: a sample is latched, a shared 32x32 squarer forms the sphere distance,
// then a compare and update step follows.
// Finish runs the bit-serial divider for each of the five means, the squarer,
// the square root and the output step, which waits until res is free.
// smp.ready is high only while no item is at work.
// The result sits in an output register: a stalled res.ready holds it, and
// begin and sample items are still taken meanwhile; a later finish waits for it.
// Reset clears configuration, accumulators and follow centre; no result is pending.
module extremum_location_tracker import elt_pkg::*; #(
	parameter longint unsigned MAX_POINTS = ELT_MAX_POINTS
) (
	input wire logic clk,
	input wire logic arst_n,
	elt_in_if.sink   smp,
	elt_out_if.source res,
	elt_cfg_if.sink  cfg
);

	elt_cmd_t cmd;

	assign cfg.ready = 1'b1;

	elt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (smp.valid),
		.opcode    (smp.opcode),
		.in_ready  (smp.ready),
		.out_ready (res.ready),
		.out_valid (res.valid),
		.cmd       (cmd)
	);

	elt_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample_value (smp.sample_value),
		.x_coord      (smp.x_coord),
		.y_coord      (smp.y_coord),
		.z_coord      (smp.z_coord),
		.skip_point   (smp.skip_point),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.mean_value   (res.mean_value),
		.mean_compare (res.mean_compare),
		.mean_x       (res.mean_x),
		.mean_y       (res.mean_y),
		.mean_z       (res.mean_z),
		.radius       (res.radius),
		.tie_count    (res.tie_count),
		.valid_res    (res.valid_res)
	);

endmodule
`default_nettype wire

### tb/sv/elt_checker.sv
`timescale 1ns / 1ps
module elt_checker import elt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	elt_in_if    smp,
	elt_out_if   res,
	elt_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);

	localparam longint SUM_HI = (64'sd1 <<< 56) - 1;
	localparam longint SUM_LO = -(64'sd1 <<< 56);
	localparam int unsigned TIE_CAP = (ELT_MAX_POINTS > 64'h1FFFFFF) ? 32'h1FFFFFF :
		int'(ELT_MAX_POINTS);

	typedef struct {
		logic [31:0] mean_value;
		logic [31:0] mean_compare;
		logic [31:0] mean_x;
		logic [31:0] mean_y;
		logic [31:0] mean_z;
		logic [31:0] radius;
		logic [24:0] tie_count;
		logic        valid_res;
	} extremum_t;

	extremum_t pending_means[$];

	// configuration copy
	logic [1:0] cmp_mode, area_mode, half_mode;
	longint cen_x, cen_y, cen_z;
	longint unsigned rad_sq;

	// accumulator copy
	longint best_cmp, val_acc, cmp_acc, x_acc, y_acc, z_acc;
	int unsigned ties;
	bit has_follow;
	longint fol_x, fol_y, fol_z;

	function automatic longint clip_sum(longint a, longint b);
		longint s;
		s = a + b;
		if (s > SUM_HI) return SUM_HI;
		if (s < SUM_LO) return SUM_LO;
		return s;
	endfunction

	function automatic longint unsigned add_square(longint unsigned acc, longint d);
		longint unsigned m, s;
		m = d < 0 ? longint'(-d) : longint'(d);
		s = acc + m * m;
		return (s < acc) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
	endfunction

	// round magnitude to nearest, halves away from zero, then clamp
	function automatic longint round_mean(longint s, int unsigned n);
		longint unsigned mag, q;
		longint r;
		mag = s < 0 ? longint'(-s) : longint'(s);
		q = (mag + longint'(n / 2)) / longint'(n);
		if (q > 64'h8000_0000) q = 64'h8000_0000;
		r = s < 0 ? -longint'(q) : longint'(q);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		return r;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root, t;
		root = 0;
		for (int i = 31; i >= 0; i--) begin
			t = root | (64'd1 << i);
			if (t * t <= v) root = t;
		end
		return root;
	endfunction

	task automatic clear_acc();
		best_cmp = 0; val_acc = 0; cmp_acc = 0; x_acc = 0; y_acc = 0; z_acc = 0;
		ties = 0;
	endtask

	task automatic take_sample(longint v, longint x, longint y, longint z, logic skip);
		longint c, cx, cy, cz;
		longint unsigned d2;
		bit better;
		if (skip) return;
		if (half_mode == HALF_SKIP_NEG && x < 0) return;
		if (half_mode == HALF_SKIP_POS && x > 0) return;
		if (area_mode == REGION_FIXED || area_mode == REGION_FOLLOW) begin
			cx = cen_x; cy = cen_y; cz = cen_z;
			if (area_mode == REGION_FOLLOW && has_follow) begin
				cx = fol_x; cy = fol_y; cz = fol_z;
			end
			d2 = add_square(0, x - cx);
			d2 = add_square(d2, y - cy);
			d2 = add_square(d2, z - cz);
			if (d2 > rad_sq) return;
		end
		c = (cmp_mode >= 2 && v < 0) ? -v : v;
		better = (cmp_mode[0] == 1'b0) ? (c > best_cmp) : (c < best_cmp);
		if (ties == 0 || better) begin
			best_cmp = c; val_acc = v; cmp_acc = c; x_acc = x; y_acc = y; z_acc = z;
			ties = 1;
		end else if (c == best_cmp && ties < TIE_CAP) begin
			val_acc = clip_sum(val_acc, v);
			cmp_acc = clip_sum(cmp_acc, c);
			x_acc = clip_sum(x_acc, x);
			y_acc = clip_sum(y_acc, y);
			z_acc = clip_sum(z_acc, z);
			ties++;
		end
	endtask

	function automatic extremum_t finish_sweep();
		extremum_t e;
		longint mx, my, mz;
		e = '{default: '0};
		if (ties > 0) begin
			mx = round_mean(x_acc, ties);
			my = round_mean(y_acc, ties);
			mz = round_mean(z_acc, ties);
			e.mean_value   = 32'(round_mean(val_acc, ties));
			e.mean_compare = 32'(round_mean(cmp_acc, ties));
			e.mean_x       = 32'(mx);
			e.mean_y       = 32'(my);
			e.mean_z       = 32'(mz);
			e.radius = 32'(floor_sqrt(add_square(add_square(add_square(0, mx), my), mz)));
			e.tie_count    = 25'(ties);
			e.valid_res    = 1'b1;
			if (area_mode == REGION_FOLLOW) begin
				fol_x = mx; fol_y = my; fol_z = mz;
				has_follow = 1'b1;
			end
		end
		return e;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		extremum_t e;
		if (!arst_n) begin
			cmp_mode = 0; area_mode = 0; half_mode = 0;
			cen_x = 0; cen_y = 0; cen_z = 0; rad_sq = 0;
			clear_acc();
			has_follow = 0; fol_x = 0; fol_y = 0; fol_z = 0;
			pending_means.delete();
			fail_count = 0;
		end else begin
			// compare a delivered result with the oldest expectation
			if (res.valid && res.ready) begin
				if (pending_means.size() == 0) begin
					$display("%0t: unexpected result, expected none, got mean_value %h",
						$realtime, res.mean_value);
					fail_count++;
				end else begin
					e = pending_means.pop_front();
					check_field("mean_value", e.mean_value, res.mean_value);
					check_field("mean_compare", e.mean_compare, res.mean_compare);
					check_field("mean_x", e.mean_x, res.mean_x);
					check_field("mean_y", e.mean_y, res.mean_y);
					check_field("mean_z", e.mean_z, res.mean_z);
					check_field("radius", e.radius, res.radius);
					check_field("tie_count", 32'(e.tie_count), 32'(res.tie_count));
					check_field("valid_res", 32'(e.valid_res), 32'(res.valid_res));
				end
			end
			// apply register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_COMPARE_MODE: cmp_mode = cfg.data[1:0];
					REG_REGION_MODE:  area_mode = cfg.data[1:0];
					REG_HALF_SPACE:   half_mode = cfg.data[1:0];
					REG_CENTER_X:     cen_x = longint'(signed'(cfg.data[31:0]));
					REG_CENTER_Y:     cen_y = longint'(signed'(cfg.data[31:0]));
					REG_CENTER_Z:     cen_z = longint'(signed'(cfg.data[31:0]));
					REG_RADIUS_SQ:    rad_sq = {1'b0, cfg.data[62:0]};
					default: ;
				endcase
			end
			// advance the prediction on each accepted item
			if (smp.valid && smp.ready) begin
				case (smp.opcode)
					OP_BEGIN:  clear_acc();
					OP_SAMPLE: take_sample(smp.sample_value, smp.x_coord, smp.y_coord,
						smp.z_coord, smp.skip_point);
					OP_FINISH: pending_means = {pending_means, finish_sweep()};
					default: ;
				endcase
			end
		end
		pending = pending_means.size();
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import elt_pkg::*;

	localparam opcode_t OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending;
	int item_count = 0;
	bit no_gaps = 0;

	elt_in_if  smp();
	elt_out_if res();
	elt_cfg_if cfg();

	extremum_location_tracker DUT (.clk(clk), .arst_n(arst_n), .smp(smp), .res(res), .cfg(cfg));

	elt_checker u_checker (.clk(clk), .arst_n(arst_n), .smp(smp), .res(res), .cfg(cfg),
		.fail_count(fail_count), .pending(pending));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		smp.valid = 0; smp.opcode = OP_BEGIN; smp.sample_value = 0;
		smp.x_coord = 0; smp.y_coord = 0; smp.z_coord = 0; smp.skip_point = 0;
		res.ready = 0;
		cfg.valid = 0; cfg.index = REG_COMPARE_MODE; cfg.data = 0;
	end

	// result side: stall a random number of cycles per item
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = no_gaps ? 0 : $urandom_range(0, 12);
			if (g > 0) begin
				res.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	task automatic send(opcode_t op, logic [31:0] v, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic skip);
		int g;
		g = no_gaps ? 0 : $urandom_range(0, 12);
		if (g > 0) begin
			smp.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.opcode <= op;
		smp.sample_value <= v;
		smp.x_coord <= x;
		smp.y_coord <= y;
		smp.z_coord <= z;
		smp.skip_point <= skip;
		do @(posedge clk); while (!smp.ready);
		item_count++;
	endtask

	task automatic sample(logic [31:0] v, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send(OP_SAMPLE, v, x, y, z, 1'b0);
	endtask

	// hold valid across back-to-back writes, drop it at the end
	task automatic write_regs(logic [63:0] vals [7]);
		for (int i = 0; i < 7; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= reg_idx_t'(i);
			cfg.data <= vals[i];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// let the checker see the last accepted item before waiting on it
	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] grid_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 6)) - 3);
			default: return 32'(($signed($urandom_range(0, 6)) - 3) <<< 16);
		endcase
	endfunction

	function automatic logic [31:0] grid_coord();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return 32'(($signed($urandom_range(0, 16)) - 8) <<< 16);
		endcase
	endfunction

	task automatic random_config();
		logic [63:0] v [7];
		for (int i = 0; i < 3; i++) v[i] = {$urandom, $urandom};
		for (int i = 3; i < 6; i++) v[i] = {$urandom, grid_coord()};
		case ($urandom_range(0, 4))
			0: v[6] = {$urandom, $urandom};
			1: v[6] = $urandom_range(0, 1) ? 64'h0 : 64'h7FFF_FFFF_FFFF_FFFF;
			default: v[6] = {32'($urandom_range(0, 120)), $urandom};
		endcase
		write_regs(v);
	endtask

	initial begin
		logic [63:0] v [7];
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, empty finish, extremes, ties, skip, unused opcode
		send(OP_FINISH, 0, 0, 0, 0, 0);
		send(OP_BEGIN, 0, 0, 0, 0, 0);
		sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(OP_SAMPLE, 32'h7FFF_FFFF, 0, 0, 0, 1'b1);
		send(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send(OP_FINISH, 0, 0, 0, 0, 0);
		send(OP_FINISH, 0, 0, 0, 0, 0);
		drain();
		// minimum of absolute with all most-negative values, follow sphere, skip x < 0
		v = '{64'd3, 64'd2, 64'd1, 64'h0, 64'h0, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF};
		write_regs(v);
		send(OP_BEGIN, 0, 0, 0, 0, 0);
		sample(32'h8000_0000, 32'h0001_0000, 0, 0);
		sample(32'h8000_0000, 32'h0003_0000, 32'h0002_0000, 0);
		sample(32'h8000_0000, 32'hFFFF_0000, 0, 0);
		send(OP_FINISH, 0, 0, 0, 0, 0);
		send(OP_BEGIN, 0, 0, 0, 0, 0);
		sample(32'h0001_0000, 0, 0, 0);
		send(OP_FINISH, 0, 0, 0, 0, 0);
		drain();
		// small fixed sphere, skip x > 0, minimum
		v = '{64'd1, 64'd1, 64'd2, 64'hFFFF_FFFF_FFFF_0000, 64'h0, 64'h0, 64'h1_0000_0000};
		write_regs(v);
		send(OP_BEGIN, 0, 0, 0, 0, 0);
		sample(32'h0000_0002, 32'hFFFF_0000, 0, 0);
		sample(32'h0000_0002, 32'hFFFE_0000, 0, 0);
		sample(32'h0000_0001, 32'h0001_0000, 0, 0);
		sample(32'h0000_0002, 32'hFFFF_0000, 0, 0);
		send(OP_FINISH, 0, 0, 0, 0, 0);
		drain();

		// random sweeps with occasional reconfiguration
		n = 0;
		while (item_count < 1700) begin
			if (n % 6 == 0) begin
				drain();
				random_config();
			end
			n++;
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) != 0) send(OP_BEGIN, $urandom, $urandom, $urandom, $urandom, 0);
			repeat ($urandom_range(1, 25)) begin
				if ($urandom_range(0, 9) == 0)
					send(opcode_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
						$urandom, 1'($urandom_range(0, 1)));
				else
					send(OP_SAMPLE, grid_value(), grid_coord(), grid_coord(), grid_coord(),
						$urandom_range(0, 7) == 0);
			end
			send(OP_FINISH, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 5) == 0) send(OP_FINISH, 0, 0, 0, 0, 0);
		end
		drain();

		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
